@@ design/greedy_heavy_edge_matching_macros.svh @@
// ----------------------------------------------------------------------------
// Greedy heavy-edge matching assertion macros
// Shared property wrappers, clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef GREEDY_HEAVY_EDGE_MATCHING_MACROS_SVH
`define GREEDY_HEAVY_EDGE_MATCHING_MACROS_SVH

// Same-cycle implication.
`define GHEM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GHEM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ghem_pkg.sv @@
// ----------------------------------------------------------------------------
// ghem_pkg
// Shared types and constants of the greedy heavy-edge matching block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ghem_pkg;

    // Default capacities.
    localparam int MAX_NODES_DEF = 128;
    localparam int MAX_EDGES_DEF = 1024;

    // Fixed field widths.
    localparam int CMD_W = 2;
    localparam int WGT_W = 16;
    localparam int NB_W  = 7;
    localparam int SQ_W  = 2 * WGT_W;
    localparam int PRD_W = SQ_W + WGT_W;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_NODE = 2'd0,
        CMD_EDGE = 2'd1,
        CMD_RUN  = 2'd2
    } t_cmd;

    // One stored edge.
    typedef struct packed {
        logic [NB_W-1:0]  nb;
        logic             loc;
        logic [WGT_W-1:0] w;
    } t_edge;

    localparam int EDGE_DW = $bits(t_edge);

endpackage

`default_nettype wire

@@ design/greedy_heavy_edge_matching.sv @@
// ----------------------------------------------------------------------------
// greedy_heavy_edge_matching
// Loads a local graph in row order and forms greedy heavy-edge pairs on run.
// ----------------------------------------------------------------------------
// Usage: one command channel (start/busy) and one result channel (o_strobe).
// A transfer is taken on a clock edge with start high and busy low.
// Node and edge commands are written straight into the graph memories, so
// busy stays low and one load may follow per cycle.
// A run command raises busy for the whole walk over the stored rows: each
// loaded node is visited, each edge of an unmatched row is read from the
// registered memories, and each live candidate passes the shared 32x16
// multiplier, which forms its square and the two cross products in turn,
// and is then compared with the best so far.
// Each pair is held until the next pair is found so the final one can carry
// o_last; the final transfer shows in the first cycle with busy low. A run
// that finds no pair gives one lone marker with o_pair_valid low and o_last
// high. Each result is on the ports for one cycle with o_strobe high; the
// receiver cannot stall. Reset empties the graph and idles the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module greedy_heavy_edge_matching #(
    parameter int MAX_NODES = ghem_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = ghem_pkg::MAX_EDGES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [ghem_pkg::CMD_W-1:0] i_command,
    input  wire logic [ghem_pkg::WGT_W-1:0] i_node_weight,
    input  wire logic [ghem_pkg::NB_W-1:0]  i_neighbor,
    input  wire logic                       i_neighbor_local,
    input  wire logic [ghem_pkg::WGT_W-1:0] i_edge_weight,
    output logic                            o_strobe,
    output logic      [ghem_pkg::NB_W-1:0]  o_first_node,
    output logic      [ghem_pkg::NB_W-1:0]  o_partner_node,
    output logic                            o_pair_valid,
    output logic                            o_last
);

    import ghem_pkg::*;

    localparam int NAW = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int ECW = $clog2(MAX_EDGES + 1);

    logic             accept;
    t_cmd             cmd;
    logic             run;
    logic [NCW-1:0]   node_count;

    logic             wgt_wr_en, wgt_rd_en;
    logic [NAW-1:0]   wgt_wr_addr, wgt_rd_addr;
    logic [WGT_W-1:0] wgt_wr_data, wgt_rd_data;
    logic             row_wr_en, row_rd_en;
    logic [NAW-1:0]   row_wr_addr, row_rd_addr;
    logic [ECW-1:0]   row_wr_data, row_rd_data;
    logic             edge_wr_en, edge_rd_en;
    logic [EAW-1:0]   edge_wr_addr, edge_rd_addr;
    t_edge            edge_wr_data, edge_rd_data;

    // Command transfer decode.
    assign accept = start && !busy;
    assign cmd    = t_cmd'(i_command);
    assign run    = accept && (cmd == CMD_RUN);

    // Graph loader.
    ghem_loader #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_loader (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (accept),
        .i_cmd            (cmd),
        .i_node_weight    (i_node_weight),
        .i_neighbor       (i_neighbor),
        .i_neighbor_local (i_neighbor_local),
        .i_edge_weight    (i_edge_weight),
        .o_node_count     (node_count),
        .o_wgt_wr_en      (wgt_wr_en),
        .o_wgt_wr_addr    (wgt_wr_addr),
        .o_wgt_wr_data    (wgt_wr_data),
        .o_row_wr_en      (row_wr_en),
        .o_row_wr_addr    (row_wr_addr),
        .o_row_wr_data    (row_wr_data),
        .o_edge_wr_en     (edge_wr_en),
        .o_edge_wr_addr   (edge_wr_addr),
        .o_edge_wr_data   (edge_wr_data)
    );

    // Node weights.
    ghem_ram #(
        .WIDTH (WGT_W),
        .DEPTH (MAX_NODES)
    ) u_wgt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wgt_wr_en),
        .i_wr_addr (wgt_wr_addr),
        .i_wr_data (wgt_wr_data),
        .i_rd_en   (wgt_rd_en),
        .i_rd_addr (wgt_rd_addr),
        .o_rd_data (wgt_rd_data)
    );

    // Row end pointers.
    ghem_ram #(
        .WIDTH (ECW),
        .DEPTH (MAX_NODES)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (row_wr_en),
        .i_wr_addr (row_wr_addr),
        .i_wr_data (row_wr_data),
        .i_rd_en   (row_rd_en),
        .i_rd_addr (row_rd_addr),
        .o_rd_data (row_rd_data)
    );

    // Edge list.
    ghem_ram #(
        .WIDTH (EDGE_DW),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .i_clk     (i_clk),
        .i_wr_en   (edge_wr_en),
        .i_wr_addr (edge_wr_addr),
        .i_wr_data (edge_wr_data),
        .i_rd_en   (edge_rd_en),
        .i_rd_addr (edge_rd_addr),
        .o_rd_data (edge_rd_data)
    );

    // Matching sequencer.
    ghem_matcher #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_matcher (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_run          (run),
        .i_node_count   (node_count),
        .o_busy         (busy),
        .o_row_rd_en    (row_rd_en),
        .o_row_rd_addr  (row_rd_addr),
        .i_row_rd_data  (row_rd_data),
        .o_edge_rd_en   (edge_rd_en),
        .o_edge_rd_addr (edge_rd_addr),
        .i_edge_rd_data (edge_rd_data),
        .o_wgt_rd_en    (wgt_rd_en),
        .o_wgt_rd_addr  (wgt_rd_addr),
        .i_wgt_rd_data  (wgt_rd_data),
        .o_strobe       (o_strobe),
        .o_first_node   (o_first_node),
        .o_partner_node (o_partner_node),
        .o_pair_valid   (o_pair_valid),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

@@ design/ghem_ram.sv @@
// ----------------------------------------------------------------------------
// ghem_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ghem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/ghem_loader.sv @@
// ----------------------------------------------------------------------------
// ghem_loader
// Appends node and edge transfers to the graph memories in row order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ghem_loader #(
    parameter int MAX_NODES = ghem_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = ghem_pkg::MAX_EDGES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_load,
    input  wire ghem_pkg::t_cmd                 i_cmd,
    input  wire logic [ghem_pkg::WGT_W-1:0]     i_node_weight,
    input  wire logic [ghem_pkg::NB_W-1:0]      i_neighbor,
    input  wire logic                           i_neighbor_local,
    input  wire logic [ghem_pkg::WGT_W-1:0]     i_edge_weight,
    output logic      [$clog2(MAX_NODES+1)-1:0] o_node_count,
    output logic                                o_wgt_wr_en,
    output logic      [$clog2(MAX_NODES)-1:0]   o_wgt_wr_addr,
    output logic      [ghem_pkg::WGT_W-1:0]     o_wgt_wr_data,
    output logic                                o_row_wr_en,
    output logic      [$clog2(MAX_NODES)-1:0]   o_row_wr_addr,
    output logic      [$clog2(MAX_EDGES+1)-1:0] o_row_wr_data,
    output logic                                o_edge_wr_en,
    output logic      [$clog2(MAX_EDGES)-1:0]   o_edge_wr_addr,
    output ghem_pkg::t_edge                     o_edge_wr_data
);

    import ghem_pkg::*;

    localparam int NAW = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int ECW = $clog2(MAX_EDGES + 1);

    logic [NCW-1:0] r_node_count, n_node_count;
    logic [ECW-1:0] r_edge_count, n_edge_count;
    logic           r_row_open, n_row_open;
    logic [NCW-1:0] last_node;
    logic           node_room;
    logic           edge_room;

    assign last_node = r_node_count - NCW'(1);
    assign node_room = (r_node_count < NCW'(MAX_NODES));
    assign edge_room = (r_edge_count < ECW'(MAX_EDGES));

    // Decode one load transfer into memory writes and counter updates.
    always_comb begin
        n_node_count   = r_node_count;
        n_edge_count   = r_edge_count;
        n_row_open     = r_row_open;
        o_wgt_wr_en    = 1'b0;
        o_wgt_wr_addr  = r_node_count[NAW-1:0];
        o_wgt_wr_data  = i_node_weight;
        o_row_wr_en    = 1'b0;
        o_row_wr_addr  = r_node_count[NAW-1:0];
        o_row_wr_data  = r_edge_count;
        o_edge_wr_en   = 1'b0;
        o_edge_wr_addr = r_edge_count[EAW-1:0];
        o_edge_wr_data = '{nb: i_neighbor, loc: i_neighbor_local, w: i_edge_weight};
        if (i_load) begin
            unique case (i_cmd)
                CMD_NODE: begin
                    if (node_room) begin
                        o_wgt_wr_en  = 1'b1;
                        o_row_wr_en  = 1'b1;
                        n_node_count = r_node_count + NCW'(1);
                        n_row_open   = 1'b1;
                    end else begin
                        n_row_open = 1'b0;
                    end
                end
                CMD_EDGE: begin
                    if (r_row_open && (r_node_count != '0) && edge_room) begin
                        o_edge_wr_en  = 1'b1;
                        o_row_wr_en   = 1'b1;
                        o_row_wr_addr = last_node[NAW-1:0];
                        o_row_wr_data = r_edge_count + ECW'(1);
                        n_edge_count  = r_edge_count + ECW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Counters and the open-row flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
            r_edge_count <= '0;
            r_row_open   <= 1'b0;
        end else begin
            r_node_count <= n_node_count;
            r_edge_count <= n_edge_count;
            r_row_open   <= n_row_open;
        end
    end

    assign o_node_count = r_node_count;

endmodule

`default_nettype wire

@@ design/ghem_matcher.sv @@
// ----------------------------------------------------------------------------
// ghem_matcher
// Run sequencer: walks the stored rows, rates candidates and emits pairs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "greedy_heavy_edge_matching_macros.svh"

module ghem_matcher #(
    parameter int MAX_NODES = ghem_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = ghem_pkg::MAX_EDGES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_run,
    input  wire logic [$clog2(MAX_NODES+1)-1:0] i_node_count,
    output logic                                o_busy,
    output logic                                o_row_rd_en,
    output logic      [$clog2(MAX_NODES)-1:0]   o_row_rd_addr,
    input  wire logic [$clog2(MAX_EDGES+1)-1:0] i_row_rd_data,
    output logic                                o_edge_rd_en,
    output logic      [$clog2(MAX_EDGES)-1:0]   o_edge_rd_addr,
    input  wire ghem_pkg::t_edge                i_edge_rd_data,
    output logic                                o_wgt_rd_en,
    output logic      [$clog2(MAX_NODES)-1:0]   o_wgt_rd_addr,
    input  wire logic [ghem_pkg::WGT_W-1:0]     i_wgt_rd_data,
    output logic                                o_strobe,
    output logic      [ghem_pkg::NB_W-1:0]      o_first_node,
    output logic      [ghem_pkg::NB_W-1:0]      o_partner_node,
    output logic                                o_pair_valid,
    output logic                                o_last
);

    import ghem_pkg::*;

    localparam int NAW = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int CW  = NB_W + 1;

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_INIT      = 12'b0000_0000_0010,
        S_NODE_RD   = 12'b0000_0000_0100,
        S_NODE_WAIT = 12'b0000_0000_1000,
        S_EDGE_RD   = 12'b0000_0001_0000,
        S_EDGE_CHK  = 12'b0000_0010_0000,
        S_MUL_SQ    = 12'b0000_0100_0000,
        S_MUL_L     = 12'b0000_1000_0000,
        S_MUL_R     = 12'b0001_0000_0000,
        S_CMP       = 12'b0010_0000_0000,
        S_NODE_END  = 12'b0100_0000_0000,
        S_FLUSH     = 12'b1000_0000_0000
    } t_state;

    t_state                r_state, n_state;
    logic [MAX_NODES-1:0]  r_matched;
    logic [NAW-1:0]        r_n;
    logic [ECW-1:0]        r_start;
    logic [ECW-1:0]        r_end;
    logic [ECW-1:0]        r_j;
    logic                  r_have_best;
    logic [NB_W-1:0]       r_best_nb;
    logic [SQ_W-1:0]       r_best_sq;
    logic [WGT_W-1:0]      r_best_nw;
    logic [NB_W-1:0]       r_cand_nb;
    logic [WGT_W-1:0]      r_cand_w;
    logic [SQ_W-1:0]       r_sq;
    logic [WGT_W-1:0]      r_nw;
    logic [PRD_W-1:0]      r_lhs;
    logic [PRD_W-1:0]      r_rhs;
    logic                  r_pend_valid;
    logic [NB_W-1:0]       r_pend_first;
    logic [NB_W-1:0]       r_pend_partner;
    logic                  r_out_strobe, n_out_strobe;
    logic [NB_W-1:0]       r_out_first;
    logic [NB_W-1:0]       r_out_partner;
    logic                  r_out_pair_valid;
    logic                  r_out_last;

    logic                  candidate;
    logic [ECW-1:0]        j_next;
    logic                  row_done;
    logic                  last_node;
    logic [SQ_W-1:0]       mul_a;
    logic [WGT_W-1:0]      mul_b;
    logic [PRD_W-1:0]      mul_p;
    logic [MAX_NODES-1:0]  match_set;

    // Candidate test on the edge word just read.
    assign candidate = i_edge_rd_data.loc
                    && (CW'(i_edge_rd_data.nb) < CW'(i_node_count))
                    && (i_edge_rd_data.nb != NB_W'(r_n))
                    && !r_matched[i_edge_rd_data.nb[NAW-1:0]];

    assign j_next    = r_j + ECW'(1);
    assign row_done  = (j_next >= r_end);
    assign last_node = ((NCW'(r_n) + NCW'(1)) == i_node_count);

    // A result leaves when a held pair is pushed out by a new one, or at flush.
    assign n_out_strobe = (r_state == S_FLUSH)
                       || ((r_state == S_NODE_END) && r_have_best && r_pend_valid);

    // Flags set by a new pair: the visited node and its partner.
    always_comb begin
        match_set                     = '0;
        match_set[r_n]                = 1'b1;
        match_set[r_best_nb[NAW-1:0]] = 1'b1;
    end

    // Memory read ports.
    assign o_row_rd_en    = (r_state == S_NODE_RD);
    assign o_row_rd_addr  = r_n;
    assign o_edge_rd_en   = (r_state == S_EDGE_RD);
    assign o_edge_rd_addr = r_j[EAW-1:0];
    assign o_wgt_rd_en    = (r_state == S_EDGE_CHK);
    assign o_wgt_rd_addr  = i_edge_rd_data.nb[NAW-1:0];

    // Shared multiplier: candidate square, then the two cross products.
    always_comb begin
        unique case (r_state)
            S_MUL_L: begin
                mul_a = r_sq;
                mul_b = r_best_nw;
            end
            S_MUL_R: begin
                mul_a = r_best_sq;
                mul_b = r_nw;
            end
            default: begin
                mul_a = SQ_W'(r_cand_w);
                mul_b = r_cand_w;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Next-state logic of the run sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_run) n_state = S_INIT;
            S_INIT:      n_state = (i_node_count == '0) ? S_FLUSH : S_NODE_RD;
            S_NODE_RD:   n_state = S_NODE_WAIT;
            S_NODE_WAIT: begin
                if (r_matched[r_n] || (i_row_rd_data <= r_start)) begin
                    n_state = S_NODE_END;
                end else begin
                    n_state = S_EDGE_RD;
                end
            end
            S_EDGE_RD:   n_state = S_EDGE_CHK;
            S_EDGE_CHK: begin
                if (candidate) begin
                    n_state = S_MUL_SQ;
                end else begin
                    n_state = row_done ? S_NODE_END : S_EDGE_RD;
                end
            end
            S_MUL_SQ:    n_state = S_MUL_L;
            S_MUL_L:     n_state = S_MUL_R;
            S_MUL_R:     n_state = S_CMP;
            S_CMP:       n_state = row_done ? S_NODE_END : S_EDGE_RD;
            S_NODE_END:  n_state = last_node ? S_FLUSH : S_NODE_RD;
            S_FLUSH:     n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_matched    <= '0;
            r_pend_valid <= 1'b0;
            r_have_best  <= 1'b0;
            r_out_strobe <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_strobe <= n_out_strobe;
            unique case (r_state)
                S_INIT: begin
                    r_matched    <= '0;
                    r_pend_valid <= 1'b0;
                end
                S_NODE_WAIT: begin
                    r_have_best <= 1'b0;
                end
                S_CMP: begin
                    if (!r_have_best || (r_lhs > r_rhs)) begin
                        r_have_best <= 1'b1;
                    end
                end
                S_NODE_END: begin
                    if (r_have_best) begin
                        r_matched    <= r_matched | match_set;
                        r_pend_valid <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers: row bounds, candidate, best so far and result.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_INIT: begin
                r_n     <= '0;
                r_start <= '0;
            end
            S_NODE_WAIT: begin
                r_end <= i_row_rd_data;
                r_j   <= r_start;
            end
            S_EDGE_CHK: begin
                r_cand_nb <= i_edge_rd_data.nb;
                r_cand_w  <= i_edge_rd_data.w;
                if (!candidate) begin
                    r_j <= j_next;
                end
            end
            S_MUL_SQ: begin
                r_sq <= mul_p[SQ_W-1:0];
                r_nw <= i_wgt_rd_data;
            end
            S_MUL_L: begin
                r_lhs <= mul_p;
            end
            S_MUL_R: begin
                r_rhs <= mul_p;
            end
            S_CMP: begin
                if (!r_have_best || (r_lhs > r_rhs)) begin
                    r_best_nb <= r_cand_nb;
                    r_best_sq <= r_sq;
                    r_best_nw <= r_nw;
                end
                r_j <= j_next;
            end
            S_NODE_END: begin
                if (r_have_best) begin
                    r_out_first      <= r_pend_first;
                    r_out_partner    <= r_pend_partner;
                    r_out_pair_valid <= 1'b1;
                    r_out_last       <= 1'b0;
                    r_pend_first     <= NB_W'(r_n);
                    r_pend_partner   <= r_best_nb;
                end
                if (r_end > r_start) begin
                    r_start <= r_end;
                end
                r_n <= r_n + NAW'(1);
            end
            S_FLUSH: begin
                r_out_first      <= r_pend_valid ? r_pend_first : '0;
                r_out_partner    <= r_pend_valid ? r_pend_partner : '0;
                r_out_pair_valid <= r_pend_valid;
                r_out_last       <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_strobe       = r_out_strobe;
    assign o_first_node   = r_out_first;
    assign o_partner_node = r_out_partner;
    assign o_pair_valid   = r_out_pair_valid;
    assign o_last         = r_out_last;

    // A run always closes with a final transfer.
    `GHEM_ASSERT_NXT(a_flush_closes, r_state == S_FLUSH, r_out_strobe && r_out_last, "run end without final transfer")
    // A lone marker only ever closes a run.
    `GHEM_ASSERT_IMP(a_lone_is_last, r_out_strobe && !r_out_pair_valid, r_out_last, "lone marker not last")
    // A pair never joins a node to itself.
    `GHEM_ASSERT_IMP(a_pair_distinct, r_out_strobe && r_out_pair_valid, r_out_first != r_out_partner, "self pair")
    // The matched flags start clear on every run.
    `GHEM_ASSERT_NXT(a_init_clears, r_state == S_INIT, r_matched == '0, "flags not cleared at run start")
    // The edge pointer stays inside the current row while scanning.
    `GHEM_ASSERT_IMP(a_j_in_row, r_state == S_EDGE_RD || r_state == S_EDGE_CHK, r_j < r_end, "edge pointer out of row")

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// Greedy heavy-edge matching testbench
// Loads graphs through the start/busy command port and predicts every pair
// that a run forms. A driver feeds commands from a queue with random gaps, and
// a monitor checks each result transfer against the oldest predicted pair.
// Directed loads cover ties, self, remote and unloaded neighbors, zero weights
// and the lone marker. Random rows follow, and the node store is then filled
// past its capacity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import ghem_pkg::*;

    localparam int MAX_NODES  = MAX_NODES_DEF;
    localparam int MAX_EDGES  = MAX_EDGES_DEF;
    localparam int CYCLE_CAP  = 1000000;
    localparam int DRAIN_CYC  = 200;
    localparam int RAND_ITEMS = 170;

    // Command code that the block ignores.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // One command as it goes onto the ports.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [WGT_W-1:0] weight;
        logic [NB_W-1:0]  nb;
        logic             loc;
        logic [WGT_W-1:0] ew;
    } t_cmd_item;

    // One pair (or lone marker) as the block reports it.
    typedef struct packed {
        logic [NB_W-1:0] first;
        logic [NB_W-1:0] partner;
        logic            valid;
        logic            last;
    } t_pair;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [CMD_W-1:0]     i_command = CMD_UNUSED;
    logic [WGT_W-1:0]     i_node_weight = '0;
    logic [NB_W-1:0]      i_neighbor = '0;
    logic                 i_neighbor_local = 1'b0;
    logic [WGT_W-1:0]     i_edge_weight = '0;
    logic                 o_strobe;
    logic [NB_W-1:0]      o_first_node;
    logic [NB_W-1:0]      o_partner_node;
    logic                 o_pair_valid;
    logic                 o_last;

    // Commands waiting to be sent, and pairs waiting to be reported.
    t_cmd_item cmd_q [$];
    t_pair     pair_q [$];
    t_cmd_item cur;
    bit        issue_now;
    int        idle_left = 0;
    bit        no_idle = 1'b0;
    int        err_cnt = 0;
    int        cycle_cnt = 0;

    // Predicted graph contents.
    logic [WGT_W-1:0] wt_mem [MAX_NODES];
    t_edge            edge_mem [MAX_EDGES];
    int               row_end [MAX_NODES];
    int               node_cnt = 0;
    int               edge_cnt = 0;
    bit               row_open = 1'b0;

    // Load counts as the generator sees them, used to aim neighbor indexes.
    int gen_nodes = 0;
    int gen_edges = 0;
    bit gen_open = 1'b0;

    greedy_heavy_edge_matching #(
        .MAX_NODES(MAX_NODES),
        .MAX_EDGES(MAX_EDGES)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_node_weight   (i_node_weight),
        .i_neighbor      (i_neighbor),
        .i_neighbor_local(i_neighbor_local),
        .i_edge_weight   (i_edge_weight),
        .o_strobe        (o_strobe),
        .o_first_node    (o_first_node),
        .o_partner_node  (o_partner_node),
        .o_pair_valid    (o_pair_valid),
        .o_last          (o_last)
    );

    always #4 i_clk = ~i_clk;

    // Walk the rows in order and pair each free node with its best free neighbor.
    task automatic match_graph();
        bit              taken [MAX_NODES];
        t_pair           found_q [$];
        t_pair           p;
        t_edge           e;
        int              row_lo;
        int              row_hi;
        int              best;
        longint unsigned w;
        longint unsigned nw;
        longint unsigned best_w;
        longint unsigned best_nw;
        row_lo = 0;
        for (int n = 0; n < node_cnt; n++) begin
            row_hi = row_end[n];
            if (!taken[n]) begin
                best = -1;
                best_w = 0;
                best_nw = 0;
                for (int j = row_lo; j < row_hi; j++) begin
                    e = edge_mem[j];
                    if (e.loc && int'(e.nb) < node_cnt && int'(e.nb) != n && !taken[e.nb]) begin
                        w = 64'(e.w);
                        nw = 64'(wt_mem[e.nb]);
                        // Exact rating compare; ties keep the earlier neighbor.
                        if (best < 0 || w * w * best_nw > best_w * best_w * nw) begin
                            best = int'(e.nb);
                            best_w = w;
                            best_nw = nw;
                        end
                    end
                end
                if (best >= 0 && found_q.size() < 64) begin
                    taken[n] = 1'b1;
                    taken[best] = 1'b1;
                    p = '{first: n[NB_W-1:0], partner: best[NB_W-1:0], valid: 1'b1,
                          last: 1'b0};
                    found_q = {found_q, p};
                end
            end
            if (row_hi > row_lo) row_lo = row_hi;
        end
        // A run without pairs reports a single lone marker.
        if (found_q.size() == 0) begin
            p = '{first: '0, partner: '0, valid: 1'b0, last: 1'b1};
            found_q = {found_q, p};
        end else begin
            found_q[found_q.size() - 1].last = 1'b1;
        end
        pair_q = {pair_q, found_q};
    endtask

    // Update the predicted graph with one accepted command.
    task automatic apply_item(input t_cmd_item it);
        t_edge e;
        case (it.cmd)
            CMD_NODE: begin
                if (node_cnt < MAX_NODES) begin
                    wt_mem[node_cnt] = it.weight;
                    row_end[node_cnt] = edge_cnt;
                    node_cnt++;
                    row_open = 1'b1;
                end else begin
                    row_open = 1'b0;
                end
            end
            CMD_EDGE: begin
                if (row_open && node_cnt > 0 && edge_cnt < MAX_EDGES) begin
                    e.nb = it.nb;
                    e.loc = it.loc;
                    e.w = it.ew;
                    edge_mem[edge_cnt] = e;
                    edge_cnt++;
                    row_end[node_cnt - 1] = edge_cnt;
                end
            end
            CMD_RUN: match_graph();
            default: ;
        endcase
    endtask

    // Random filler for the fields that a command does not use.
    function automatic t_cmd_item rand_fields();
        t_cmd_item it;
        it.cmd = CMD_UNUSED;
        it.weight = WGT_W'($urandom);
        it.nb = NB_W'($urandom);
        it.loc = 1'($urandom);
        it.ew = WGT_W'($urandom);
        return it;
    endfunction

    task automatic add_node(input logic [WGT_W-1:0] w);
        t_cmd_item it;
        it = rand_fields();
        it.cmd = CMD_NODE;
        it.weight = w;
        cmd_q = {cmd_q, it};
        if (gen_nodes < MAX_NODES) begin
            gen_nodes++;
            gen_open = 1'b1;
        end else begin
            gen_open = 1'b0;
        end
    endtask

    task automatic add_edge(input logic [NB_W-1:0] nb, input logic loc,
                            input logic [WGT_W-1:0] ew);
        t_cmd_item it;
        it = rand_fields();
        it.cmd = CMD_EDGE;
        it.nb = nb;
        it.loc = loc;
        it.ew = ew;
        cmd_q = {cmd_q, it};
        if (gen_open && gen_nodes > 0 && gen_edges < MAX_EDGES) gen_edges++;
    endtask

    task automatic add_cmd(input logic [CMD_W-1:0] code);
        t_cmd_item it;
        it = rand_fields();
        it.cmd = code;
        cmd_q = {cmd_q, it};
    endtask

    // Node weights lean toward small values so that ties and zeros show up.
    function automatic logic [WGT_W-1:0] pick_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return WGT_W'($urandom_range(1, 8));
        if (r < 45) return '0;
        if (r < 50) return '1;
        return WGT_W'($urandom);
    endfunction

    function automatic logic [WGT_W-1:0] pick_ew();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return WGT_W'($urandom_range(0, 15));
        if (r < 40) return '0;
        if (r < 45) return '1;
        return WGT_W'($urandom);
    endfunction

    // Most neighbors point at loaded nodes or just past them.
    function automatic logic [NB_W-1:0] pick_nb();
        int hi;
        hi = (gen_nodes + 1 > MAX_NODES - 1) ? MAX_NODES - 1 : gen_nodes + 1;
        if ($urandom_range(0, 99) < 85) return NB_W'($urandom_range(0, hi));
        return NB_W'($urandom_range(0, MAX_NODES - 1));
    endfunction

    // Sender gaps: mostly none or short, a few long, with idle-free stretches.
    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 39) == 0) no_idle = ~no_idle;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Driver: a transfer happens on an edge with start high and busy low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            issue_now = start;
            if (start && !busy) begin
                apply_item(cur);
                idle_left = pick_gap();
                issue_now = 1'b0;
            end
            if (!issue_now) begin
                if (idle_left > 0) begin
                    idle_left--;
                end else if (cmd_q.size() > 0) begin
                    cur = cmd_q.pop_front();
                    i_command <= cur.cmd;
                    i_node_weight <= cur.weight;
                    i_neighbor <= cur.nb;
                    i_neighbor_local <= cur.loc;
                    i_edge_weight <= cur.ew;
                    issue_now = 1'b1;
                end
            end
            start <= issue_now;
        end
    end

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    // Monitor: every strobed result is matched against the oldest predicted pair.
    always @(posedge i_clk) begin
        t_pair p;
        if (i_rst_n && o_strobe) begin
            if (pair_q.size() == 0) begin
                $error("unexpected result: first_node %0d, partner_node %0d",
                       o_first_node, o_partner_node);
                err_cnt++;
            end else begin
                p = pair_q.pop_front();
                check_field("first_node", int'(p.first), int'(o_first_node));
                check_field("partner_node", int'(p.partner), int'(o_partner_node));
                check_field("pair_valid", int'(p.valid), int'(o_pair_valid));
                check_field("last", int'(p.last), int'(o_last));
            end
        end
    end

    // Cycle limit.
    initial begin
        while (cycle_cnt < CYCLE_CAP) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Stimulus and end of run.
    initial begin
        int r;
        int n_rand;
        int n_edges;

        // Directed part: dropped edge, empty run, unused command.
        add_edge(7'd5, 1'b1, 16'd10);
        add_cmd(CMD_RUN);
        add_cmd(CMD_UNUSED);
        // Node 0: self, remote and unloaded neighbors, then a rating tie.
        add_node(16'hFFFF);
        add_edge(7'd0, 1'b1, 16'hFFFF);
        add_edge(7'd1, 1'b0, 16'hFFFF);
        add_edge(7'd127, 1'b1, 16'hFFFF);
        add_edge(7'd1, 1'b1, 16'd1);
        add_edge(7'd2, 1'b1, 16'd2);
        add_node(16'd1);
        // Node 2 picks between two zero-weight neighbors.
        add_node(16'd4);
        add_edge(7'd3, 1'b1, 16'd0);
        add_edge(7'd4, 1'b1, 16'hFFFF);
        add_node(16'd0);
        // Node 4 only points at a node that is already taken.
        add_node(16'd0);
        add_edge(7'd2, 1'b1, 16'd3);
        add_node(16'd300);
        add_edge(7'd4, 1'b1, 16'd0);
        add_cmd(CMD_RUN);
        add_cmd(CMD_RUN);

        // Random rows with runs in between and some noise.
        n_rand = 0;
        while (n_rand < RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 82) begin
                add_node(pick_weight());
                n_edges = $urandom_range(0, 5);
                for (int k = 0; k < n_edges; k++)
                    add_edge(pick_nb(), $urandom_range(0, 9) != 0, pick_ew());
                n_rand += 1 + n_edges;
            end else if (r < 92) begin
                add_cmd(CMD_RUN);
                n_rand++;
            end else if (r < 96) begin
                add_edge(NB_W'($urandom), 1'($urandom), WGT_W'($urandom));
                n_rand++;
            end else begin
                add_cmd(CMD_UNUSED);
                n_rand++;
            end
        end
        add_cmd(CMD_RUN);

        // Fill the node store with short rows.
        while (gen_nodes < MAX_NODES) begin
            add_node(pick_weight());
            if ($urandom_range(0, 3) == 0)
                add_edge(pick_nb(), $urandom_range(0, 9) != 0, pick_ew());
        end
        add_cmd(CMD_RUN);
        // Node beyond capacity and the edges behind it are dropped.
        add_node(pick_weight());
        add_edge(7'd0, 1'b1, 16'hFFFF);
        add_edge(7'd1, 1'b1, 16'hFFFF);
        add_cmd(CMD_RUN);
        add_cmd(CMD_RUN);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every command is taken and every pair reported.
        do @(negedge i_clk);
        while (cmd_q.size() != 0 || start || idle_left != 0 || pair_q.size() != 0);
        repeat (DRAIN_CYC) @(negedge i_clk);

        if (err_cnt == 0 && pair_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/ghem_pkg.sv
design/ghem_ram.sv
design/ghem_loader.sv
design/ghem_matcher.sv
design/greedy_heavy_edge_matching.sv
tb/sv/tb.sv
